// ===== sv/ftia_pkg.sv =====
// Shared types and constants for the flow table with idle aging.
package ftia_pkg;

	localparam int CAPACITY    = 64;
	localparam int HANDLE_BITS = 8;

	localparam logic [1:0] FUNC_PACKET = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_CLEAN  = 2'd2;
	localparam logic [1:0] FUNC_FLUSH  = 2'd3;

	localparam logic [7:0] PROTO_ICMP   = 8'd1;
	localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

	localparam logic [31:0] TIMEOUT_RESET = 32'd2000;

	typedef struct packed {
		logic [1:0]  func;
		logic        is_ipv6;
		logic [7:0]  l4_proto;
		logic        fwd_known;
		logic [7:0]  fwd_handle;
		logic [63:0] src_high;
		logic [63:0] src_low;
		logic [63:0] dst_high;
		logic [63:0] dst_low;
		logic [31:0] now;
	} in_item_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] fwd_out;
		logic       inserted;
		logic       full_drop;
		logic [6:0] entry_count;
	} out_item_t;

endpackage

// ===== sv/flow_table_with_idle_aging_top.sv =====
// Top level of the flow table with idle aging: scan sequencer and entry memory.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one command beat: packet
//   observe, lookup, clean expired or flush all. out channel (out_valid/
//   out_ready/out_data) returns exactly one result beat per command.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes idle_timeout; write it
//   only while the block is idle.
// Operation:
//   Every command walks all CAPACITY entries, one per cycle, through the
//   entry memory's single read port (registered read), then evaluates the
//   last read, stamps or inserts, and forms the result. A new command is
//   not accepted until the current one has been through all these steps.
// Reset:
//   arst_n clears every valid bit, the live count and idle_timeout (to 2000).
//   No clearing pass is needed; key stores are read only under a valid bit.
// Stall:
//   The result waits in an output register while out_ready is low; the next
//   command is accepted meanwhile and its result waits in a second register,
//   which holds off further commands until it moves on.
module flow_table_with_idle_aging_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ftia_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ftia_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);
	import ftia_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = 1 + 256;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_INS  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// entry memory: key, handle and stamp (no reset)
	logic [KW-1:0]          key_mem [CAPACITY];
	logic [HANDLE_BITS-1:0] hdl_mem [CAPACITY];
	logic [31:0]            ts_mem  [CAPACITY];
	logic [CAPACITY-1:0]    valid_q;

	logic [2:0]             state_q;
	in_item_t               cmd_q;
	logic [KW-1:0]          key_q;
	logic                   track_q;
	logic [AW:0]            addr_q;
	logic [AW-1:0]          addr_s1;
	logic                   rd_s1;
	logic [KW-1:0]          rkey_s1;
	logic [HANDLE_BITS-1:0] rhdl_s1;
	logic [31:0]            rts_s1;
	logic                   found_q;
	logic [AW-1:0]          found_idx_q;
	logic [HANDLE_BITS-1:0] found_hdl_q;
	logic                   free_q;
	logic [AW-1:0]          free_idx_q;
	logic [CW-1:0]          count_q;
	logic [31:0]            timeout_q;
	out_item_t              res_q;
	logic                   res_valid_q;
	out_item_t              out_q;
	logic                   out_valid_q;

	logic [KW-1:0] in_key;
	logic          in_track;
	logic          in_fire;
	logic          out_free;
	logic          rd_live;
	logic          rd_match;
	logic          rd_expire;
	logic [31:0]   age;

	always_comb begin
		if (in_data.is_ipv6) begin
			in_key = {1'b1, in_data.src_high, in_data.src_low,
				in_data.dst_high, in_data.dst_low};
			in_track = in_data.fwd_known && (in_data.l4_proto == PROTO_ICMPV6);
		end else begin
			in_key = {1'b0, 64'd0, 32'd0, in_data.src_low[31:0],
				64'd0, 32'd0, in_data.dst_low[31:0]};
			in_track = in_data.fwd_known && (in_data.l4_proto == PROTO_ICMP);
		end
	end

	assign in_ready  = (state_q == ST_IDLE) && !res_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	assign rd_live   = rd_s1 && valid_q[addr_s1];
	assign rd_match  = rd_live && (rkey_s1 == key_q);
	assign age       = cmd_q.now - rts_s1;
	assign rd_expire = rd_live && ((cmd_q.func == FUNC_FLUSH) || (age > timeout_q));

	// memory ports: one read per cycle during scan, one write for stamp/insert
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			rkey_s1 <= key_mem[addr_q[AW-1:0]];
			rhdl_s1 <= hdl_mem[addr_q[AW-1:0]];
			rts_s1  <= ts_mem[addr_q[AW-1:0]];
		end
		// only tracked packets stamp or insert
		if (state_q == ST_INS && cmd_q.func == FUNC_PACKET && track_q) begin
			if (found_q) begin
				ts_mem[found_idx_q] <= cmd_q.now;
			end else if (free_q) begin
				key_mem[free_idx_q] <= key_q;
				hdl_mem[free_idx_q] <= cmd_q.fwd_handle[HANDLE_BITS-1:0];
				ts_mem[free_idx_q]  <= cmd_q.now;
			end
		end
		addr_s1 <= addr_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			count_q     <= '0;
			timeout_q   <= TIMEOUT_RESET;
			addr_q      <= '0;
			rd_s1       <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			// move a finished result into the output register
			if (out_free) begin
				out_valid_q <= res_valid_q;
				if (res_valid_q) begin
					out_q       <= res_q;
					res_valid_q <= 1'b0;
				end
			end
			rd_s1 <= (state_q == ST_SCAN);
			unique case (state_q) inside
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q   <= in_data;
						key_q   <= in_key;
						track_q <= in_track;
						addr_q  <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN, ST_LAST: begin
					if (state_q == ST_SCAN) begin
						addr_q <= addr_q + (AW+1)'(1);
						if (addr_q == (AW+1)'(CAPACITY - 1)) begin
							state_q <= ST_LAST;
						end
					end
					// evaluate the entry read last cycle
					if (rd_s1) begin
						if (cmd_q.func == FUNC_CLEAN || cmd_q.func == FUNC_FLUSH) begin
							if (rd_expire) begin
								valid_q[addr_s1] <= 1'b0;
								count_q <= count_q - CW'(1);
							end
						end else begin
							if (rd_match && !found_q) begin
								found_q     <= 1'b1;
								found_idx_q <= addr_s1;
								found_hdl_q <= rhdl_s1;
							end
							if (!valid_q[addr_s1] && !free_q) begin
								free_q     <= 1'b1;
								free_idx_q <= addr_s1;
							end
						end
					end
					if (state_q == ST_LAST) begin
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					// stamp or insert for tracked packets; others just report
					res_q.hit       <= 1'b0;
					res_q.fwd_out   <= '0;
					res_q.inserted  <= 1'b0;
					res_q.full_drop <= 1'b0;
					if (cmd_q.func == FUNC_PACKET && track_q) begin
						if (found_q) begin
							res_q.hit     <= 1'b1;
							res_q.fwd_out <= 8'(found_hdl_q);
						end else if (free_q) begin
							valid_q[free_idx_q] <= 1'b1;
							count_q <= count_q + CW'(1);
							res_q.inserted <= 1'b1;
						end else begin
							res_q.full_drop <= 1'b1;
						end
					end else if (cmd_q.func == FUNC_LOOKUP && found_q) begin
						res_q.hit     <= 1'b1;
						res_q.fwd_out <= 8'(found_hdl_q);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q) begin
						res_q.entry_count <= 7'(count_q);
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== sv/ftia_checker.sv =====
// Port-level checker for the flow table with idle aging, bound to the top.
module ftia_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input ftia_pkg::out_item_t out_data
);
	import ftia_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while busy");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.inserted)
			&& !(out_data.inserted && out_data.full_drop))
		else $error("conflicting result flags");

	a_fwd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.fwd_out == 8'd0)
		else $error("handle without hit");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_count <= 7'(CAPACITY))
		else $error("entry count out of range");
endmodule

bind flow_table_with_idle_aging_top ftia_checker u_ftia_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
